### sv/sse_pkg.sv
// ----------------------------------------------------------------------------
// sse_pkg: shared types and constants for the sprite scanline evaluator
// Holds the transaction payloads, opcodes, sequencer states and sizing.
// ----------------------------------------------------------------------------
package sse_pkg;

  localparam int OAM_ENTRIES = 64;
  localparam int LINE_SLOTS  = 8;

  localparam int OAM_ROWS = 64;
  localparam int ROW_W    = 6;
  localparam int CNT_W    = $clog2(LINE_SLOTS + 1);
  localparam int SLOT_W   = (LINE_SLOTS > 1) ? $clog2(LINE_SLOTS) : 1;

  localparam logic [ROW_W-1:0] ENTRY_LAST = ROW_W'(OAM_ENTRIES - 1);
  localparam logic [CNT_W-1:0] SLOTS_FULL = CNT_W'(LINE_SLOTS);

  localparam logic [4:0] HEIGHT_SMALL = 5'd8;
  localparam logic [4:0] HEIGHT_LARGE = 5'd16;

  typedef enum logic [1:0] {
    OP_SET_ADDR = 2'd0,
    OP_WRITE    = 2'd1,
    OP_READ     = 2'd2,
    OP_EVAL     = 2'd3
  } sse_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_EMIT
  } sse_state_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data_byte;
    logic [8:0] scanline;
  } sse_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       is_sprite;
    logic [7:0] sprite_y;
    logic [7:0] sprite_tile;
    logic [7:0] sprite_attr;
    logic [7:0] sprite_x;
    logic [3:0] sprite_count;
    logic       overflow;
    logic       sprite0_in_range;
    logic       last;
  } sse_out_t;

  typedef struct packed {
    logic [7:0] y;
    logic [7:0] tile;
    logic [7:0] attr;
    logic [7:0] x;
  } sse_sprite_t;

  typedef struct packed {
    logic             we;
    logic [7:0]       waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [ROW_W-1:0] rrow;
  } sse_oam_req_t;

endpackage

### sv/sprite_scanline_evaluator.sv
// ----------------------------------------------------------------------------
// sprite_scanline_evaluator: per-scanline sprite selection
// Attribute memory load/read port and an evaluator that picks up to eight
// sprites for a scanline, then emits them and a summary.
// ----------------------------------------------------------------------------
// Set-address and write transactions are handled as they are accepted; a read
// registers the attribute row, then waits until the output is free. An evaluate
// scans entries in order at one entry per cycle through the attribute memory's
// row read port and one shared range comparator, until the last entry or until
// a ninth in-range sprite ends the scan early. The selected sprites and the
// summary then leave one per cycle while the output is taken. Input is not
// ready during a read or an evaluate. Reset clears the memory's per-row valid
// bits at once; there is no clearing pass.
module sprite_scanline_evaluator (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sse_pkg::sse_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sse_pkg::sse_out_t out_data_o
);
  import sse_pkg::*;

  sse_state_e       state_q, state_d;
  logic [7:0]       addr_q, addr_d;
  logic             large_q;
  logic [ROW_W-1:0] e_q, e_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] k_q, k_d;
  logic             ovf_q, ovf_d;
  logic             s0_q, s0_d;
  logic [8:0]       scan_q, scan_d;
  logic             out_valid_q, out_valid_d;
  sse_out_t         out_q, out_d;

  sse_oam_req_t     oam_req;
  logic [3:0][7:0]  oam_rdata;
  sse_sprite_t      row_spr;
  sse_sprite_t      lb_rdata;
  logic             lb_we;
  logic             accept;
  logic             out_free;
  logic [9:0]       diff;
  logic [4:0]       height;
  logic             hit;

  sse_oam u_oam (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (oam_req),
    .rdata_o (oam_rdata)
  );

  assign row_spr = '{y: oam_rdata[0], tile: oam_rdata[1],
                     attr: oam_rdata[2], x: oam_rdata[3]};

  sse_line_buf u_line_buf (
    .clk_i   (clk_i),
    .we_i    (lb_we),
    .widx_i  (count_q[SLOT_W-1:0]),
    .wdata_i (row_spr),
    .ridx_i  (k_q[SLOT_W-1:0]),
    .rdata_o (lb_rdata)
  );

  assign height = large_q ? HEIGHT_LARGE : HEIGHT_SMALL;
  assign diff   = {1'b0, scan_q} - {2'b00, row_spr.y};
  assign hit    = !diff[9] && (diff[8:0] < {4'b0000, height});

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    e_d         = e_q;
    count_d     = count_q;
    k_d         = k_q;
    ovf_d       = ovf_q;
    s0_d        = s0_q;
    scan_d      = scan_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    lb_we       = 1'b0;
    oam_req     = '0;
    oam_req.waddr = addr_q;
    oam_req.wdata = in_data_i.data_byte;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (sse_op_e'(in_data_i.opcode))
            OP_SET_ADDR: begin
              addr_d = in_data_i.data_byte;
            end
            OP_WRITE: begin
              oam_req.we = 1'b1;
              addr_d     = addr_q + 8'd1;
            end
            OP_READ: begin
              oam_req.re   = 1'b1;
              oam_req.rrow = addr_q[7:2];
              state_d      = ST_READ;
            end
            OP_EVAL: begin
              oam_req.re = 1'b1;
              e_d        = '0;
              count_d    = '0;
              ovf_d      = 1'b0;
              s0_d       = 1'b0;
              scan_d     = in_data_i.scanline;
              state_d    = ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        if (out_free) begin
          out_valid_d     = 1'b1;
          out_d           = '0;
          out_d.read_data = oam_rdata[addr_q[1:0]];
          out_d.last      = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (e_q == '0) begin
          s0_d = hit;
        end
        if (hit && (count_q == SLOTS_FULL)) begin
          ovf_d   = 1'b1;
          k_d     = '0;
          state_d = ST_EMIT;
        end else begin
          if (hit) begin
            lb_we   = 1'b1;
            count_d = count_q + 1'b1;
          end
          if (e_q == ENTRY_LAST) begin
            k_d     = '0;
            state_d = ST_EMIT;
          end else begin
            oam_req.re   = 1'b1;
            oam_req.rrow = e_q + 1'b1;
            e_d          = e_q + 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '0;
          if (k_q == count_q) begin
            out_d.sprite_count     = 4'(count_q);
            out_d.overflow         = ovf_q;
            out_d.sprite0_in_range = s0_q;
            out_d.last             = 1'b1;
            state_d                = ST_IDLE;
          end else begin
            out_d.is_sprite   = 1'b1;
            out_d.sprite_y    = lb_rdata.y;
            out_d.sprite_tile = lb_rdata.tile;
            out_d.sprite_attr = lb_rdata.attr;
            out_d.sprite_x    = lb_rdata.x;
            k_d               = k_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      addr_q      <= '0;
      large_q     <= 1'b0;
      e_q         <= '0;
      count_q     <= '0;
      k_q         <= '0;
      ovf_q       <= 1'b0;
      s0_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      e_q         <= e_d;
      count_q     <= count_d;
      k_q         <= k_d;
      ovf_q       <= ovf_d;
      s0_q        <= s0_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        large_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q <= scan_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN || state_q == ST_EMIT) |-> (count_q <= SLOTS_FULL))
    else $error("selected count beyond line slots");

  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (k_q <= count_q))
    else $error("emit index beyond selected count");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.overflow) |->
      (out_data_o.sprite_count == 4'(LINE_SLOTS)))
    else $error("overflow reported with free slots");

  a_sprite_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.is_sprite) |-> !out_data_o.last)
    else $error("sprite result marked last");
`endif

endmodule

### sv/sse_oam.sv
// ----------------------------------------------------------------------------
// sse_oam: sprite attribute memory
// 64 rows of four bytes, byte writes, one registered row read per cycle.
// Per-row valid bits make never-written rows read as zero.
// ----------------------------------------------------------------------------
module sse_oam (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sse_pkg::sse_oam_req_t req_i,
  output logic [3:0][7:0]       rdata_o
);
  import sse_pkg::*;

  logic [3:0][7:0]   mem_q [OAM_ROWS];
  logic [OAM_ROWS-1:0] valid_q;
  logic [3:0][7:0]   rd_q;
  logic              rd_valid_q;
  logic [ROW_W-1:0]  wrow;
  logic [1:0]        wlane;

  assign wrow  = req_i.waddr[7:2];
  assign wlane = req_i.waddr[1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        valid_q[wrow] <= 1'b1;
      end
      if (req_i.re) begin
        rd_valid_q <= valid_q[req_i.rrow];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      for (int l = 0; l < 4; l++) begin
        if (wlane == 2'(l)) begin
          mem_q[wrow][l] <= req_i.wdata;
        end else if (!valid_q[wrow]) begin
          mem_q[wrow][l] <= '0;
        end
      end
    end
    if (req_i.re) begin
      rd_q <= mem_q[req_i.rrow];
    end
  end

  assign rdata_o = rd_valid_q ? rd_q : '0;

endmodule

### sv/sse_line_buf.sv
// ----------------------------------------------------------------------------
// sse_line_buf: line store for the sprites selected on one scanline
// One slot written per cycle during the scan, one slot read during emission.
// ----------------------------------------------------------------------------
module sse_line_buf (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [sse_pkg::SLOT_W-1:0]   widx_i,
  input  sse_pkg::sse_sprite_t         wdata_i,
  input  logic [sse_pkg::SLOT_W-1:0]   ridx_i,
  output sse_pkg::sse_sprite_t         rdata_o
);
  import sse_pkg::*;

  sse_sprite_t slot_q [LINE_SLOTS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      slot_q[widx_i] <= wdata_i;
    end
  end

  assign rdata_o = slot_q[ridx_i];

endmodule
